// File: hdl/l2e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// l2e_pkg
// Shared types and constants of the geodetic to ECEF converter.
// ----------------------------------------------------------------------------
package l2e_pkg;

  typedef logic signed [63:0] q60_t;

  localparam q60_t Q60_ONE     = 64'sd1152921504606846976;
  localparam q60_t THREE_Q60   = 64'sd3458764513820540928;
  localparam q60_t PI_Q60      = 64'sd3622009729038561421;
  localparam q60_t HALF_PI_Q60 = 64'sd1811004864519280711;
  localparam logic [63:0] TWO_PI_Q60 = 64'd7244019458077122842;
  localparam q60_t TURN_RECIP  = 64'sd683565276;
  localparam q60_t E2_Q60      = 64'sd7718094650643700;
  localparam q60_t OME2_Q60    = 64'sd1145203409956203276;
  localparam q60_t SEMI_MAJOR_MM = 64'sd6378137000;
  localparam q60_t OUT_LIMIT   = 64'sd6500000000;

  localparam int K_W          = 12;
  localparam int MUL_LAT      = 4;
  localparam int SC_TERMS     = 14;
  localparam int NEWTON_STEPS = 6;
  localparam int SC_LAT       = 2 + MUL_LAT + SC_TERMS * (2 * MUL_LAT + 1);

  function automatic logic [63:0] abs_q(input q60_t v);
    abs_q = v[63] ? 64'(-v) : 64'(v);
  endfunction

endpackage
`default_nettype wire

// File: hdl/l2e_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// l2e_ifs
// Stream channels: geodetic point in, ECEF word out.
// ----------------------------------------------------------------------------
interface l2e_lla_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] latitude;
  logic signed [31:0] longitude;
  logic signed [27:0] altitude_mm;

  modport source (output valid, latitude, longitude, altitude_mm, input ready);
  modport sink   (input valid, latitude, longitude, altitude_mm, output ready);
endinterface

interface l2e_ecef_if;
  logic               valid;
  logic               ready;
  logic signed [33:0] ecef_x_mm;
  logic signed [33:0] ecef_y_mm;
  logic signed [33:0] ecef_z_mm;

  modport source (output valid, ecef_x_mm, ecef_y_mm, ecef_z_mm, input ready);
  modport sink   (input valid, ecef_x_mm, ecef_y_mm, ecef_z_mm, output ready);
endinterface
`default_nettype wire

// File: hdl/l2e_mulsh.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// l2e_mulsh
// Pipelined 64x64 signed multiply, shift right, optional round half away from
// zero, saturate. Built from four 32x32 partial products.
// ----------------------------------------------------------------------------
module l2e_mulsh import l2e_pkg::*; #(
  parameter int SHIFT = 60,
  parameter bit ROUND = 1'b1
) (
  input  logic        clk,
  input  logic        en,
  input  q60_t        a,
  input  logic [63:0] b_mag,
  input  logic        b_neg,
  output q60_t        res
);

  localparam logic [127:0] RND = ROUND ? (128'd1 << (SHIFT - 1)) : 128'd0;

  logic [63:0]  am;
  logic [63:0]  bm;
  logic         neg0;
  logic         neg1;
  logic         neg2;
  logic [63:0]  pp_ll;
  logic [63:0]  pp_lh;
  logic [63:0]  pp_hl;
  logic [63:0]  pp_hh;
  logic [127:0] acc;
  logic [127:0] sh;
  logic [62:0]  mag;

  assign sh  = acc >> SHIFT;
  assign mag = (|sh[127:63]) ? '1 : sh[62:0];

  always_ff @(posedge clk) begin
    if (en) begin
      am    <= abs_q(a);
      bm    <= b_mag;
      neg0  <= a[63] ^ b_neg;
      pp_ll <= am[31:0] * bm[31:0];
      pp_lh <= am[31:0] * bm[63:32];
      pp_hl <= am[63:32] * bm[31:0];
      pp_hh <= am[63:32] * bm[63:32];
      neg1  <= neg0;
      acc   <= {pp_hh, 64'd0} + {32'd0, pp_lh, 32'd0} + {32'd0, pp_hl, 32'd0}
               + {64'd0, pp_ll} + RND;
      neg2  <= neg1;
      res   <= neg2 ? -q60_t'({1'b0, mag}) : q60_t'({1'b0, mag});
    end
  end

endmodule
`default_nettype wire

// File: hdl/l2e_sincos.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// l2e_sincos
// Pipelined sine and cosine of a reduced Q60 angle: fold to the half circle,
// then a Taylor series, one term per section.
// ----------------------------------------------------------------------------
module l2e_sincos import l2e_pkg::*; (
  input  logic clk,
  input  logic en,
  input  q60_t ang,
  output q60_t sn,
  output q60_t cs
);

  localparam int DL = 2 * MUL_LAT;

  q60_t xf;
  logic flf;
  q60_t x2;
  q60_t xd [1:MUL_LAT];
  logic fd [1:MUL_LAT];
  q60_t ts_a [0:SC_TERMS-1];
  q60_t tc_a [0:SC_TERMS-1];
  q60_t x2_a [0:SC_TERMS-1];
  q60_t ss_a [0:SC_TERMS];
  q60_t cc_a [0:SC_TERMS];
  logic fl_a [0:SC_TERMS];

  // fold into [-pi/2, pi/2]
  always_ff @(posedge clk) begin
    if (en) begin
      if (ang > HALF_PI_Q60) begin
        xf  <= PI_Q60 - ang;
        flf <= 1'b1;
      end else if (ang < -HALF_PI_Q60) begin
        xf  <= -PI_Q60 - ang;
        flf <= 1'b1;
      end else begin
        xf  <= ang;
        flf <= 1'b0;
      end
      xd[1] <= xf;
      fd[1] <= flf;
      for (int i = 2; i <= MUL_LAT; i++) begin
        xd[i] <= xd[i-1];
        fd[i] <= fd[i-1];
      end
    end
  end

  l2e_mulsh #(.SHIFT(60), .ROUND(1'b1)) u_sq (
    .clk(clk), .en(en), .a(xf), .b_mag(abs_q(xf)), .b_neg(xf[63]), .res(x2)
  );

  assign ts_a[0] = xd[MUL_LAT];
  assign ss_a[0] = xd[MUL_LAT];
  assign tc_a[0] = Q60_ONE;
  assign cc_a[0] = Q60_ONE;
  assign x2_a[0] = x2;
  assign fl_a[0] = fd[MUL_LAT];

  for (genvar k = 1; k <= SC_TERMS; k++) begin : g_term
    localparam int DS = (2 * k) * (2 * k + 1);
    localparam int DC = (2 * k - 1) * (2 * k);
    localparam int LS = $clog2(DS);
    localparam int LC = $clog2(DC);
    localparam logic [127:0] RS = ((128'd1 << (63 + LS)) + 128'(DS) - 128'd1) / DS;
    localparam logic [127:0] RC = ((128'd1 << (63 + LC)) + 128'(DC) - 128'd1) / DC;

    q60_t ms;
    q60_t mc;
    q60_t qs;
    q60_t qc;
    q60_t ssd [1:DL];
    q60_t ccd [1:DL];
    logic fld [1:DL];

    l2e_mulsh #(.SHIFT(60), .ROUND(1'b1)) u_ms (
      .clk(clk), .en(en), .a(ts_a[k-1]), .b_mag(x2_a[k-1]), .b_neg(1'b0), .res(ms)
    );
    l2e_mulsh #(.SHIFT(60), .ROUND(1'b1)) u_mc (
      .clk(clk), .en(en), .a(tc_a[k-1]), .b_mag(x2_a[k-1]), .b_neg(1'b0), .res(mc)
    );
    // divide by the factorial step through a rounded-up reciprocal, negated
    l2e_mulsh #(.SHIFT(63 + LS), .ROUND(1'b0)) u_ds (
      .clk(clk), .en(en), .a(ms), .b_mag(RS[63:0]), .b_neg(1'b1), .res(qs)
    );
    l2e_mulsh #(.SHIFT(63 + LC), .ROUND(1'b0)) u_dc (
      .clk(clk), .en(en), .a(mc), .b_mag(RC[63:0]), .b_neg(1'b1), .res(qc)
    );

    always_ff @(posedge clk) begin
      if (en) begin
        ssd[1] <= ss_a[k-1];
        ccd[1] <= cc_a[k-1];
        fld[1] <= fl_a[k-1];
        for (int i = 2; i <= DL; i++) begin
          ssd[i] <= ssd[i-1];
          ccd[i] <= ccd[i-1];
          fld[i] <= fld[i-1];
        end
        ss_a[k] <= ssd[DL] + qs;
        cc_a[k] <= ccd[DL] + qc;
        fl_a[k] <= fld[DL];
      end
    end

    if (k < SC_TERMS) begin : g_fwd
      q60_t x2d [1:DL];
      always_ff @(posedge clk) begin
        if (en) begin
          x2d[1] <= x2_a[k-1];
          for (int i = 2; i <= DL; i++) x2d[i] <= x2d[i-1];
          ts_a[k] <= qs;
          tc_a[k] <= qc;
          x2_a[k] <= x2d[DL];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn <= ss_a[SC_TERMS];
      cs <= fl_a[SC_TERMS] ? -cc_a[SC_TERMS] : cc_a[SC_TERMS];
    end
  end

endmodule
`default_nettype wire

// File: hdl/lla_to_ecef_wgs84_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lla_to_ecef_wgs84_core
// WGS-84 geodetic (latitude, longitude, height) to ECEF X, Y, Z in mm.
// ----------------------------------------------------------------------------
// Usage:
//   lla  : valid/ready sink; one word holds latitude and longitude (radians,
//          signed, ANGLE_FRAC_BITS fraction bits) and altitude_mm.
//   ecef : valid/ready source; one word holds X, Y, Z in mm, rounded to the
//          nearest mm and saturated at +-6500000000.
//   Three angle reduction stages feed the sine/cosine series, then the six
//   Newton steps of 1/sqrt.
//   Throughput is one word per cycle while ecef does not stall; the
//   multipliers are pipelined, built from 32x32 partial products.
//   Reset clears the valid bits only; data registers are not reset.
//   When ecef stalls with a word waiting, the whole pipeline holds and
//   lla.ready drops; while the output stage is empty or taken, lla.ready
//   stays high.
// ----------------------------------------------------------------------------
module lla_to_ecef_wgs84_core import l2e_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 29
) (
  input  logic           clk,
  input  logic           rst,
  l2e_lla_if.sink        lla,
  l2e_ecef_if.source     ecef
);

  localparam bit   DO_RED = ANGLE_FRAC_BITS < 31;
  localparam int   PSH    = DO_RED ? ANGLE_FRAC_BITS + 32 : 0;
  localparam int   PB_SH  = DO_RED ? ANGLE_FRAC_BITS + 31 : 0;
  localparam q60_t PBIAS  = DO_RED ? q60_t'(64'd1 << PB_SH) : 64'sd0;
  localparam int   USH    = 60 - ANGLE_FRAC_BITS;

  localparam int E_REL   = 2 * MUL_LAT;
  localparam int W_REL   = E_REL + 1;
  localparam int IT      = 3 * MUL_LAT + 1;
  localparam int Y_REL   = W_REL + NEWTON_STEPS * IT;
  localparam int N_REL   = Y_REL + MUL_LAT;
  localparam int R_REL   = N_REL + 1;
  localparam int A_REL   = R_REL + MUL_LAT;
  localparam int F_REL   = A_REL + MUL_LAT;
  localparam int T1      = 3 + SC_LAT;
  localparam int LT      = T1 + F_REL + 1;
  localparam int WD_N    = IT * (NEWTON_STEPS - 1) + MUL_LAT;
  localparam int ALT_N   = T1 + N_REL + MUL_LAT;

  function automatic logic [33:0] clamp_mm(input q60_t v);
    if (v > OUT_LIMIT) clamp_mm = OUT_LIMIT[33:0];
    else if (v < -OUT_LIMIT) clamp_mm = 34'(-OUT_LIMIT);
    else clamp_mm = v[33:0];
  endfunction

  logic en;
  logic vld [1:LT];

  q60_t lat_v1, lon_v1, lat_v2, lon_v2;
  q60_t lat_p, lon_p;
  logic signed [K_W-1:0] lat_k, lon_k;
  q60_t lat_u, lon_u;
  logic signed [27:0] alt_d [1:ALT_N];

  q60_t slat, clat, slon, clon;
  q60_t sl_d [1:A_REL];
  q60_t cl_d [1:R_REL];
  q60_t so_d [1:A_REL];
  q60_t co_d [1:A_REL];

  q60_t s2, e2s, w;
  q60_t wd [1:WD_N];
  q60_t y_a [0:NEWTON_STEPS];
  q60_t n20, zn, r20, z20, ax, xr, yr, zr;

  assign en        = !ecef.valid || ecef.ready;
  assign lla.ready = en;
  assign ecef.valid = vld[LT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= LT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[1] <= lla.valid;
      for (int i = 2; i <= LT; i++) vld[i] <= vld[i-1];
    end
  end

  // reduce each angle modulo 2*pi
  always_ff @(posedge clk) begin
    if (en) begin
      lat_v1 <= q60_t'(lla.latitude);
      lon_v1 <= q60_t'(lla.longitude);
      lat_p  <= q60_t'(lla.latitude) * TURN_RECIP + PBIAS;
      lon_p  <= q60_t'(lla.longitude) * TURN_RECIP + PBIAS;
      lat_v2 <= lat_v1;
      lon_v2 <= lon_v1;
      lat_k  <= DO_RED ? K_W'(lat_p >>> PSH) : '0;
      lon_k  <= DO_RED ? K_W'(lon_p >>> PSH) : '0;
      lat_u  <= q60_t'((64'(lat_v2) << USH) - 64'(q60_t'(lat_k)) * TWO_PI_Q60);
      lon_u  <= q60_t'((64'(lon_v2) << USH) - 64'(q60_t'(lon_k)) * TWO_PI_Q60);
      alt_d[1] <= lla.altitude_mm;
      for (int i = 2; i <= ALT_N; i++) alt_d[i] <= alt_d[i-1];
    end
  end

  l2e_sincos u_sc_lat (.clk(clk), .en(en), .ang(lat_u), .sn(slat), .cs(clat));
  l2e_sincos u_sc_lon (.clk(clk), .en(en), .ang(lon_u), .sn(slon), .cs(clon));

  always_ff @(posedge clk) begin
    if (en) begin
      sl_d[1] <= slat;
      so_d[1] <= slon;
      co_d[1] <= clon;
      cl_d[1] <= clat;
      for (int i = 2; i <= A_REL; i++) begin
        sl_d[i] <= sl_d[i-1];
        so_d[i] <= so_d[i-1];
        co_d[i] <= co_d[i-1];
      end
      for (int i = 2; i <= R_REL; i++) cl_d[i] <= cl_d[i-1];
    end
  end

  // w = 1 - e2 sin^2 lat
  l2e_mulsh #(.SHIFT(60), .ROUND(1'b1)) u_s2 (
    .clk(clk), .en(en), .a(slat), .b_mag(abs_q(slat)), .b_neg(slat[63]), .res(s2)
  );
  l2e_mulsh #(.SHIFT(60), .ROUND(1'b1)) u_e2 (
    .clk(clk), .en(en), .a(E2_Q60), .b_mag(s2), .b_neg(1'b0), .res(e2s)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      w     <= Q60_ONE - e2s;
      wd[1] <= w;
      for (int i = 2; i <= WD_N; i++) wd[i] <= wd[i-1];
    end
  end

  // Newton steps for 1/sqrt(w)
  assign y_a[0] = Q60_ONE;

  for (genvar s = 0; s < NEWTON_STEPS; s++) begin : g_newton
    localparam int YD = 2 * MUL_LAT + 1;
    q60_t yy;
    q60_t t;
    q60_t dd;
    q60_t yd [1:YD];

    l2e_mulsh #(.SHIFT(60), .ROUND(1'b1)) u_yy (
      .clk(clk), .en(en), .a(y_a[s]), .b_mag(abs_q(y_a[s])), .b_neg(y_a[s][63]),
      .res(yy)
    );
    l2e_mulsh #(.SHIFT(60), .ROUND(1'b1)) u_t (
      .clk(clk), .en(en), .a(wd[IT * s + MUL_LAT]), .b_mag(yy), .b_neg(1'b0), .res(t)
    );

    always_ff @(posedge clk) begin
      if (en) begin
        dd    <= THREE_Q60 - t;
        yd[1] <= y_a[s];
        for (int i = 2; i <= YD; i++) yd[i] <= yd[i-1];
      end
    end

    l2e_mulsh #(.SHIFT(61), .ROUND(1'b1)) u_y (
      .clk(clk), .en(en), .a(yd[YD]), .b_mag(abs_q(dd)), .b_neg(dd[63]), .res(y_a[s+1])
    );
  end

  // radii in Q20 mm
  l2e_mulsh #(.SHIFT(40), .ROUND(1'b1)) u_n (
    .clk(clk), .en(en), .a(SEMI_MAJOR_MM), .b_mag(abs_q(y_a[NEWTON_STEPS])),
    .b_neg(y_a[NEWTON_STEPS][63]), .res(n20)
  );
  l2e_mulsh #(.SHIFT(60), .ROUND(1'b1)) u_zn (
    .clk(clk), .en(en), .a(n20), .b_mag(OME2_Q60), .b_neg(1'b0), .res(zn)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      r20 <= n20 + (q60_t'(alt_d[T1 + N_REL]) <<< 20);
      z20 <= zn + (q60_t'(alt_d[ALT_N]) <<< 20);
    end
  end

  l2e_mulsh #(.SHIFT(60), .ROUND(1'b1)) u_ax (
    .clk(clk), .en(en), .a(r20), .b_mag(abs_q(cl_d[R_REL])), .b_neg(cl_d[R_REL][63]),
    .res(ax)
  );
  l2e_mulsh #(.SHIFT(80), .ROUND(1'b1)) u_x (
    .clk(clk), .en(en), .a(ax), .b_mag(abs_q(co_d[A_REL])), .b_neg(co_d[A_REL][63]),
    .res(xr)
  );
  l2e_mulsh #(.SHIFT(80), .ROUND(1'b1)) u_yv (
    .clk(clk), .en(en), .a(ax), .b_mag(abs_q(so_d[A_REL])), .b_neg(so_d[A_REL][63]),
    .res(yr)
  );
  l2e_mulsh #(.SHIFT(80), .ROUND(1'b1)) u_z (
    .clk(clk), .en(en), .a(z20), .b_mag(abs_q(sl_d[A_REL])), .b_neg(sl_d[A_REL][63]),
    .res(zr)
  );

  // saturate and hold the output word
  always_ff @(posedge clk) begin
    if (en) begin
      ecef.ecef_x_mm <= clamp_mm(xr);
      ecef.ecef_y_mm <= clamp_mm(yr);
      ecef.ecef_z_mm <= clamp_mm(zr);
    end
  end

endmodule
`default_nettype wire

// File: hdl/l2e_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// l2e_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module l2e_checker (
  input wire              clk,
  input wire              rst,
  input wire              in_ready,
  input wire              out_valid,
  input wire              out_ready,
  input wire signed [33:0] x,
  input wire signed [33:0] y,
  input wire signed [33:0] z
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(x) && $stable(y) && $stable(z))
    else $error("output word changed while stalled");

  a_in_open: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked with output stage free");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> x <= 34'sd6500000000 && x >= -34'sd6500000000 &&
                  y <= 34'sd6500000000 && y >= -34'sd6500000000 &&
                  z <= 34'sd6500000000 && z >= -34'sd6500000000)
    else $error("output beyond saturation limit");

endmodule

bind lla_to_ecef_wgs84_core l2e_checker u_l2e_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(lla.ready),
  .out_valid(ecef.valid),
  .out_ready(ecef.ready),
  .x(ecef.ecef_x_mm),
  .y(ecef.ecef_y_mm),
  .z(ecef.ecef_z_mm)
);
`default_nettype wire
